// ===== rtl/arp_responder_with_cache_macros.svh =====
// assertion macros for the arp responder rtl
// no dependencies; expects clk and rst in the including module
`ifndef ARP_RESPONDER_WITH_CACHE_MACROS_SVH
`define ARP_RESPONDER_WITH_CACHE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ARPRC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ARPRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/arprc_pkg.sv =====
// package for the arp responder with cache: depths, codes, probe and write structs
// no dependencies
package arprc_pkg;

  localparam int TABLE_DEPTH   = 32;
  localparam int PENDING_DEPTH = 16;
  localparam int IFACE_BITS    = 4;

  localparam int TBL_IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int TBL_CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int PND_IDX_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

  localparam int IP_W     = 32;
  localparam int MAC_W    = 48;
  localparam int OPER_W   = 16;
  localparam int IFACE_W  = 4;
  localparam int TIME_W   = 32;
  localparam int OUTOP_W  = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 48;

  localparam int IN_DATA_W  = 168;
  localparam int OUT_DATA_W = 136;

  localparam logic [OPER_W-1:0]  OPER_CODE_REQUEST = 16'd1;
  localparam logic [OPER_W-1:0]  OPER_CODE_REPLY   = 16'd2;
  localparam logic [OUTOP_W-1:0] OUT_OP_REQUEST = 2'd1;
  localparam logic [OUTOP_W-1:0] OUT_OP_REPLY   = 2'd2;
  localparam logic               OPC_PACKET     = 1'b0;
  localparam logic               OPC_RESOLVE    = 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC = 1'b1;
  localparam logic [MAC_W-1:0]   BCAST_MAC = {MAC_W{1'b1}};
  localparam logic [IFACE_W-1:0] IFACE_MASK = IFACE_W'((2 ** IFACE_BITS) - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_EMIT
  } st_t;

  typedef struct packed {
    logic            active;
    logic [IP_W-1:0] ip;
    logic            found;
  } tbl_probe_t;

  typedef struct packed {
    logic                 en;
    logic [TBL_IDX_W-1:0] idx;
    logic [IP_W-1:0]      ip;
    logic [MAC_W-1:0]     mac;
  } tbl_wr_t;

  typedef struct packed {
    logic                 active;
    logic                 clear;
    logic [IP_W-1:0]      ip;
    logic                 match;
    logic                 free_found;
    logic [PND_IDX_W-1:0] free_idx;
  } pnd_probe_t;

  typedef struct packed {
    logic                  en;
    logic [PND_IDX_W-1:0]  idx;
    logic [IP_W-1:0]       ip;
    logic [IFACE_BITS-1:0] iface;
    logic [TIME_W-1:0]     ts;
  } pnd_wr_t;

endpackage

// ===== rtl/arp_responder_with_cache.sv =====
// ARP responder with learning cache. A request is taken only while the block is idle;
// a lookup probe then runs down a chain of TABLE_DEPTH table cells and, alongside, a
// chain of PENDING_DEPTH pending cells, one cell per cycle. The block returns to idle
// once both probes reach the tail of their chains and the table and pending updates
// are made; a request with a result (a reply to an ARP request, or an ARP request for a
// resolve with no pending match) is first loaded into the output register, waiting while
// that register still holds a previous result that has not been taken.
// s_tuser is the opcode (0 received packet, 1 resolve), m_tuser the ARP operation to
// send (1 request, 2 reply). Configuration writes (index 0 own_ip, 1 own_mac) are always
// ready and belong to idle periods.
// depends on arprc_pkg, arprc_ctrl, arprc_tbl_cell, arprc_pnd_cell
module arp_responder_with_cache (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [arprc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [arprc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // arp_oper[15:0], sender_ip[47:16], sender_mac[95:48], target_ip[127:96],
  // iface[131:128], timestamp[163:132], zero pad
  input  logic [arprc_pkg::IN_DATA_W-1:0]  s_tdata,
  // opcode
  input  logic                             s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // out_target_ip[31:0], out_dest_mac[79:32], out_target_mac[127:80],
  // out_iface[131:128], zero pad
  output logic [arprc_pkg::OUT_DATA_W-1:0] m_tdata,
  // out_oper
  output logic [arprc_pkg::OUTOP_W-1:0]    m_tuser
);
  import arprc_pkg::*;

  tbl_probe_t tbl_probe [TABLE_DEPTH+1];
  pnd_probe_t pnd_probe [PENDING_DEPTH+1];
  tbl_wr_t    tbl_wr;
  pnd_wr_t    pnd_wr;
  logic [TBL_CNT_W-1:0] tbl_count;

  arprc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .tbl_launch (tbl_probe[0]),
    .tbl_end    (tbl_probe[TABLE_DEPTH]),
    .tbl_wr     (tbl_wr),
    .tbl_count  (tbl_count),
    .pnd_launch (pnd_probe[0]),
    .pnd_end    (pnd_probe[PENDING_DEPTH]),
    .pnd_wr     (pnd_wr)
  );

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_tbl
    arprc_tbl_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .idx       (TBL_IDX_W'(i)),
      .count     (tbl_count),
      .probe_in  (tbl_probe[i]),
      .probe_out (tbl_probe[i+1]),
      .wr        (tbl_wr)
    );
  end

  for (genvar j = 0; j < PENDING_DEPTH; j++) begin : g_pnd
    arprc_pnd_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .idx       (PND_IDX_W'(j)),
      .probe_in  (pnd_probe[j]),
      .probe_out (pnd_probe[j+1]),
      .wr        (pnd_wr)
    );
  end

endmodule

// ===== rtl/arprc_tbl_cell.sv =====
// one learning table entry; passes the lookup probe to its neighbor each cycle
// depends on arprc_pkg
module arprc_tbl_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [arprc_pkg::TBL_IDX_W-1:0] idx,
  input  logic [arprc_pkg::TBL_CNT_W-1:0] count,
  input  arprc_pkg::tbl_probe_t          probe_in,
  output arprc_pkg::tbl_probe_t          probe_out,
  input  arprc_pkg::tbl_wr_t             wr
);
  import arprc_pkg::*;

  logic [IP_W-1:0]  ip;
  logic [MAC_W-1:0] mac;
  logic             in_use;
  logic             hit;

  assign in_use = TBL_CNT_W'(idx) < count;
  assign hit    = in_use && (ip == probe_in.ip);

  always_ff @(posedge clk) begin
    if (wr.en && (wr.idx == idx)) begin
      ip  <= wr.ip;
      mac <= wr.mac;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out.active <= 1'b0;
    end else begin
      probe_out.active <= probe_in.active;
    end
    probe_out.ip    <= probe_in.ip;
    probe_out.found <= probe_in.found | hit;
  end

endmodule

// ===== rtl/arprc_pnd_cell.sv =====
// one pending resolve entry; passes the match and free-slot probe to its neighbor
// depends on arprc_pkg
module arprc_pnd_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [arprc_pkg::PND_IDX_W-1:0] idx,
  input  arprc_pkg::pnd_probe_t          probe_in,
  output arprc_pkg::pnd_probe_t          probe_out,
  input  arprc_pkg::pnd_wr_t             wr
);
  import arprc_pkg::*;

  logic                  valid;
  logic [IP_W-1:0]       ip;
  logic [IFACE_BITS-1:0] iface;
  logic [TIME_W-1:0]     ts;
  logic                  hit;
  logic                  wr_here;

  assign hit     = valid && (ip == probe_in.ip);
  assign wr_here = wr.en && (wr.idx == idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr_here) begin
      valid <= 1'b1;
    end else if (probe_in.active && probe_in.clear && hit && !probe_in.match) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_here) begin
      ip    <= wr.ip;
      iface <= wr.iface;
      ts    <= wr.ts;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out.active <= 1'b0;
    end else begin
      probe_out.active <= probe_in.active;
    end
    probe_out.clear      <= probe_in.clear;
    probe_out.ip         <= probe_in.ip;
    probe_out.match      <= probe_in.match | hit;
    probe_out.free_found <= probe_in.free_found | !valid;
    probe_out.free_idx   <= probe_in.free_found ? probe_in.free_idx : idx;
  end

endmodule

// ===== rtl/arprc_ctrl.sv =====
// sequencer: config registers, request decode, probe launch, table and pending updates,
// output register; depends on arprc_pkg and arp_responder_with_cache_macros.svh
`include "arp_responder_with_cache_macros.svh"

module arprc_ctrl (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [arprc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [arprc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [arprc_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                             s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [arprc_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic [arprc_pkg::OUTOP_W-1:0]    m_tuser,
  output arprc_pkg::tbl_probe_t            tbl_launch,
  input  arprc_pkg::tbl_probe_t            tbl_end,
  output arprc_pkg::tbl_wr_t               tbl_wr,
  output logic [arprc_pkg::TBL_CNT_W-1:0]  tbl_count,
  output arprc_pkg::pnd_probe_t            pnd_launch,
  input  arprc_pkg::pnd_probe_t            pnd_end,
  output arprc_pkg::pnd_wr_t               pnd_wr
);
  import arprc_pkg::*;

  st_t state;
  st_t state_next;

  logic [IP_W-1:0]  own_ip;
  logic [MAC_W-1:0] own_mac;

  logic [OPER_W-1:0]  in_oper;
  logic [IP_W-1:0]    in_sip;
  logic [MAC_W-1:0]   in_smac;
  logic [IP_W-1:0]    in_tip;
  logic [IFACE_W-1:0] in_iface;
  logic [TIME_W-1:0]  in_ts;

  logic [IP_W-1:0]    sip;
  logic [MAC_W-1:0]   smac;
  logic [IP_W-1:0]    tip;
  logic [IFACE_W-1:0] ifc;
  logic [TIME_W-1:0]  ts;
  logic               is_req;
  logic               is_rep;
  logic               is_res;

  logic                 tdone;
  logic                 pdone;
  logic                 tfound;
  logic                 pmatch;
  logic                 pfree_found;
  logic [PND_IDX_W-1:0] pfree_idx;

  logic accept;
  logic load_out;
  logic learn;
  logic alloc;
  logic pkt_ok;

  assign in_oper  = s_tdata[15:0];
  assign in_sip   = s_tdata[47:16];
  assign in_smac  = s_tdata[95:48];
  assign in_tip   = s_tdata[127:96];
  assign in_iface = s_tdata[131:128] & IFACE_MASK;
  assign in_ts    = s_tdata[163:132];

  assign cfg_ready = 1'b1;
  assign pkt_ok    = (s_tuser == OPC_PACKET) && (in_tip == own_ip);

  always_ff @(posedge clk) begin
    if (rst) begin
      own_ip  <= '0;
      own_mac <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_OWN_IP:  own_ip  <= cfg_data[IP_W-1:0];
        CFG_OWN_MAC: own_mac <= cfg_data[MAC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    load_out   = 1'b0;
    learn      = 1'b0;
    alloc      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tdone && pdone) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        learn = (is_req || is_rep) && !tfound && (tbl_count < TBL_CNT_W'(TABLE_DEPTH));
        alloc = is_res && !pmatch && pfree_found;
        if (is_req || (is_res && !pmatch)) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign accept = s_tvalid && s_tready;

  // latched request
  always_ff @(posedge clk) begin
    if (accept) begin
      sip  <= in_sip;
      smac <= in_smac;
      tip  <= in_tip;
      ifc  <= in_iface;
      ts   <= in_ts;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      is_req <= 1'b0;
      is_rep <= 1'b0;
      is_res <= 1'b0;
    end else if (accept) begin
      is_req <= pkt_ok && (in_oper == OPER_CODE_REQUEST);
      is_rep <= pkt_ok && (in_oper == OPER_CODE_REPLY);
      is_res <= (s_tuser == OPC_RESOLVE);
    end
  end

  // probe launch into the head of both chains
  always_ff @(posedge clk) begin
    if (rst) begin
      tbl_launch.active <= 1'b0;
      pnd_launch.active <= 1'b0;
    end else begin
      tbl_launch.active <= accept;
      pnd_launch.active <= accept;
    end
    if (accept) begin
      tbl_launch.ip <= in_sip;
      pnd_launch.ip <= (s_tuser == OPC_RESOLVE) ? in_tip : in_sip;
      pnd_launch.clear <= pkt_ok && (in_oper == OPER_CODE_REPLY);
    end
    tbl_launch.found      <= 1'b0;
    pnd_launch.match      <= 1'b0;
    pnd_launch.free_found <= 1'b0;
    pnd_launch.free_idx   <= '0;
  end

  // chain tail capture
  always_ff @(posedge clk) begin
    if (rst) begin
      tdone <= 1'b0;
      pdone <= 1'b0;
    end else if (accept) begin
      tdone <= 1'b0;
      pdone <= 1'b0;
    end else begin
      if (tbl_end.active) begin
        tdone <= 1'b1;
      end
      if (pnd_end.active) begin
        pdone <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_end.active) begin
      tfound <= tbl_end.found;
    end
    if (pnd_end.active) begin
      pmatch      <= pnd_end.match;
      pfree_found <= pnd_end.free_found;
      pfree_idx   <= pnd_end.free_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tbl_count <= '0;
    end else if (learn) begin
      tbl_count <= tbl_count + TBL_CNT_W'(1);
    end
  end

  always_comb begin
    tbl_wr.en  = learn;
    tbl_wr.idx = tbl_count[TBL_IDX_W-1:0];
    tbl_wr.ip  = sip;
    tbl_wr.mac = smac;
    pnd_wr.en    = alloc;
    pnd_wr.idx   = pfree_idx;
    pnd_wr.ip    = tip;
    pnd_wr.iface = IFACE_BITS'(ifc);
    pnd_wr.ts    = ts;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (is_req) begin
        m_tuser <= OUT_OP_REPLY;
        m_tdata <= {4'd0, {IFACE_W{1'b0}}, smac, smac, sip};
      end else begin
        m_tuser <= OUT_OP_REQUEST;
        m_tdata <= {4'd0, ifc, {MAC_W{1'b0}}, BCAST_MAC, tip};
      end
    end
  end

  `ARPRC_ASSERT_NOW(a_count_bound, 1'b1, tbl_count <= TBL_CNT_W'(TABLE_DEPTH), "count overflow")
  `ARPRC_ASSERT_NOW(a_learn_room, tbl_wr.en, tbl_count < TBL_CNT_W'(TABLE_DEPTH), "full table")
  `ARPRC_ASSERT_NOW(a_alloc_free, pnd_wr.en, pfree_found && !pmatch && is_res, "bad pending alloc")
  `ARPRC_ASSERT_NOW(a_tbl_tail, tbl_end.active, state == ST_SCAN, "table probe outside scan")
  `ARPRC_ASSERT_NOW(a_pnd_tail, pnd_end.active, state == ST_SCAN, "pending probe outside scan")
  `ARPRC_ASSERT_NEXT(a_accept_scan, accept, state == ST_SCAN, "accept did not start scan")

endmodule
